FILE: rtl/texture_row_half_float_framer_unit_assert.svh
// Assertion macros used by the texture row framer back end.
`ifndef TEXTURE_ROW_HALF_FLOAT_FRAMER_UNIT_ASSERT_SVH
`define TEXTURE_ROW_HALF_FLOAT_FRAMER_UNIT_ASSERT_SVH

// Check a property at every rising edge, ignored while reset is asserted.
`define TFRM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TFRM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: rtl/tfrm_pkg.sv
// Shared constants, types and phase codes for the texture row framer.
`default_nettype none
package tfrm_pkg;

    localparam int TEXELS_PER_ROW     = 64;
    localparam int COMPONENTS_PER_ROW = 3 * TEXELS_PER_ROW;
    localparam int CNT_W              = $clog2(COMPONENTS_PER_ROW);

    localparam logic [7:0]  ROW_MARKER    = 8'hAF;
    localparam logic [15:0] HALF_INF      = 16'h7c00;
    localparam logic [15:0] HALF_QNAN_BIT = 16'h0200;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One converted component on its way from front to back.
    typedef struct packed {
        logic [7:0]  row;
        logic [15:0] half;
        logic        first;
        logic        last;
    } tfrm_entry_t;

    typedef enum logic [2:0] {
        PH_MARK,
        PH_ROW,
        PH_LO,
        PH_HI,
        PH_CSUM
    } tfrm_phase_t;

endpackage
`default_nettype wire

FILE: rtl/tfrm_front.sv
// Front end: accepts components, converts them to half precision, tags row position.
`default_nettype none
module tfrm_front
    import tfrm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [7:0] row_index, [39:8] component_bits
    input  wire logic        q_full,
    output logic             q_push,
    output tfrm_entry_t      q_entry
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             row_last;

    logic [31:0] bits;
    logic        sign;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [23:0] mant24;
    logic [4:0]  sh;
    logic [23:0] sub_shift;
    logic [23:0] rnd_shift;
    logic [10:0] sub_r;
    logic [14:0] norm_base;
    logic        norm_inc;
    logic [14:0] norm_r;
    logic [15:0] half;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign row_last = (count_reg == CNT_W'(COMPONENTS_PER_ROW - 1));

    // binary32 to binary16
    always_comb begin
        bits      = s_tdata[39:8];
        sign      = bits[31];
        bexp      = bits[30:23];
        mant      = bits[22:0];
        mant24    = {1'b1, mant};
        sh        = 5'(8'd126 - bexp);
        sub_shift = mant24 >> sh;
        rnd_shift = mant24 >> (sh - 5'd1);
        sub_r     = sub_shift[10:0] + {10'd0, rnd_shift[0]};
        norm_base = {5'(bexp - 8'd112), mant[22:13]};
        norm_inc  = mant[12] && ((mant[11:0] != 12'd0) || mant[13]);
        norm_r    = norm_base + {14'd0, norm_inc};
        priority if (bexp == 8'hff) begin
            half = {sign, 15'd0} | HALF_INF | ((mant != 23'd0) ? HALF_QNAN_BIT : 16'd0);
        end else if (bexp >= 8'd143) begin
            half = {sign, 15'd0} | HALF_INF;
        end else if (bexp < 8'd102) begin
            half = {sign, 15'd0};
        end else if (bexp <= 8'd112) begin
            half = {sign, 4'd0, sub_r};
        end else begin
            half = {sign, norm_r};
        end
    end

    always_comb begin
        q_entry.row   = s_tdata[7:0];
        q_entry.half  = half;
        q_entry.first = (count_reg == '0);
        q_entry.last  = row_last;
        count_next    = count_reg;
        if (q_push) begin
            count_next = row_last ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tfrm_queue.sv
// Short queue between the front end and the byte sequencer.
`default_nettype none
module tfrm_queue
    import tfrm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire tfrm_entry_t push_entry,
    output logic             full,
    input  wire logic        pop,
    output logic             q_valid,
    output tfrm_entry_t      q_entry
);

    tfrm_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;

    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/tfrm_back.sv
// Back end: walks each queued component through its packet bytes, and the checksum after the last one of a row.
`default_nettype none
`include "texture_row_half_float_framer_unit_assert.svh"
module tfrm_back
    import tfrm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire tfrm_entry_t q_entry,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast
);

    tfrm_entry_t cur_reg;
    logic        cur_valid_reg;
    logic        cur_valid_next;
    tfrm_phase_t phase_reg;
    tfrm_phase_t phase_next;
    logic [7:0]  csum_reg;
    logic [7:0]  csum_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [7:0]  m_data_reg;
    logic        m_last_reg;

    logic        out_load;
    logic        emit;
    logic        finish;
    logic [7:0]  byte_sel;
    logic        last_sel;

    assign out_load = !m_valid_reg || m_tready;
    assign emit     = cur_valid_reg && out_load;
    assign finish   = emit && ((phase_reg == PH_HI && !cur_reg.last) || phase_reg == PH_CSUM);
    assign q_pop    = q_valid && (!cur_valid_reg || finish);

    // next state
    always_comb begin
        phase_next     = phase_reg;
        cur_valid_next = cur_valid_reg;
        csum_next      = csum_reg;
        if (emit) begin
            unique case (phase_reg)
                PH_MARK: begin
                    phase_next = PH_ROW;
                end
                PH_ROW: begin
                    phase_next = PH_LO;
                    csum_next  = cur_reg.row;
                end
                PH_LO: begin
                    phase_next = PH_HI;
                    csum_next  = csum_reg ^ cur_reg.half[7:0];
                end
                PH_HI: begin
                    phase_next = PH_CSUM;
                    csum_next  = csum_reg ^ cur_reg.half[15:8];
                end
                PH_CSUM: begin
                    csum_next = 8'h00;
                end
                default: begin
                    phase_next = PH_LO;
                end
            endcase
        end
        if (finish) begin
            cur_valid_next = 1'b0;
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            phase_next     = q_entry.first ? PH_MARK : PH_LO;
        end
    end

    // byte selection
    always_comb begin
        last_sel = 1'b0;
        unique case (phase_reg)
            PH_MARK: byte_sel = ROW_MARKER;
            PH_ROW:  byte_sel = cur_reg.row;
            PH_LO:   byte_sel = cur_reg.half[7:0];
            PH_HI:   byte_sel = cur_reg.half[15:8];
            PH_CSUM: begin
                byte_sel = csum_reg;
                last_sel = 1'b1;
            end
            default: byte_sel = 8'h00;
        endcase
        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_entry;
        end
        if (emit) begin
            m_data_reg <= byte_sel;
            m_last_reg <= last_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_MARK;
            csum_reg      <= 8'h00;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            phase_reg     <= phase_next;
            csum_reg      <= csum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `TFRM_ASSERT(a_csum_cleared, aclk, aresetn,
        (emit && phase_reg == PH_CSUM) |=> (csum_reg == 8'h00),
        "checksum not cleared after packet end")
    `TFRM_ASSERT(a_csum_only_last, aclk, aresetn,
        (cur_valid_reg && phase_reg == PH_CSUM) |-> cur_reg.last,
        "checksum phase on a non-final component")
    `TFRM_ASSERT(a_marker_out, aclk, aresetn,
        (emit && phase_reg == PH_MARK) |=> (m_data_reg == ROW_MARKER && !m_last_reg),
        "marker byte not presented")
    `TFRM_ASSERT_NEVER(a_pop_mid_item, aclk, aresetn,
        q_pop && cur_valid_reg && !emit,
        "queue popped while a component is still being sent")

endmodule
`default_nettype wire

FILE: rtl/texture_row_half_float_framer_unit.sv
// Top level of the texture row half-float packet framer.
// An item's first byte reaches m_tdata via the queue, the current-item and output registers.
// Throughput: one output byte per cycle through a single output register while m_tready is
//   high; an item is 2 bytes, 4 for the first of a row (marker, row), 3 for the last.
// A two-entry queue lets the input side accept while earlier bytes are still draining.
// Reset (aresetn low, synchronous) clears the row position, checksum, queue and output valid.
`default_nettype none
module texture_row_half_float_framer_unit
    import tfrm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [7:0] row_index, [39:8] component_bits
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast    // last_byte: set on the checksum byte
);

    // Converted components waiting for the byte sequencer.
    logic        q_full;
    logic        q_push;
    tfrm_entry_t push_entry;
    logic        q_pop;
    logic        q_valid;
    tfrm_entry_t q_entry;

    // Front: take a component, convert it, note its place in the row.
    tfrm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // Queue: decouple the conversion from byte-rate output.
    tfrm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    // Back: emit marker, row, half bytes and checksum one item at a time.
    tfrm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
